### rtl/dit_pkg.sv
// ----------------------------------------------------------------------------
// dit_pkg
// Shared types and constants for the dual interval timer with interrupt.
// ----------------------------------------------------------------------------
package dit_pkg;

  localparam int COUNT_W = 16;
  localparam int SPAN_W  = 13;

  localparam int TICK_RATE_DEF = 960;
  localparam int TIMER_DIV_DEF = 55555;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [1:0] PORT_ADDR0 = 2'd0;
  localparam logic [1:0] PORT_DATA0 = 2'd1;
  localparam logic [1:0] PORT_ADDR1 = 2'd2;
  localparam logic [1:0] PORT_DATA1 = 2'd3;

  localparam logic [7:0] REG_TA_HI = 8'h24;
  localparam logic [7:0] REG_TA_LO = 8'h25;
  localparam logic [7:0] REG_TB    = 8'h26;
  localparam logic [7:0] REG_MODE  = 8'h27;

  localparam logic [7:0] MODE_RESET = 8'h30;

  localparam int MODE_RUN_A = 0;
  localparam int MODE_RUN_B = 1;
  localparam int MODE_EN_A  = 2;
  localparam int MODE_EN_B  = 3;
  localparam int MODE_CLR_A = 4;
  localparam int MODE_CLR_B = 5;

  localparam logic [10:0] TA_SPAN = 11'd1024;
  localparam logic [8:0]  TB_SPAN = 9'd256;

  typedef struct packed {
    logic tick;
    logic mode_wr;
    logic run;
    logic en;
    logic clr;
  } timer_ctl_t;

endpackage

### rtl/dit_scale.sv
// ----------------------------------------------------------------------------
// dit_scale
// Converts a timer span into a tick count: span * TICK_RATE / TIMER_DIV,
// floored, limited to 1 .. 2^COUNT_W-1. Uses a fixed-point reciprocal that
// is exact over the whole span range.
// ----------------------------------------------------------------------------
module dit_scale #(
  parameter int TICK_RATE = dit_pkg::TICK_RATE_DEF,
  parameter int TIMER_DIV = dit_pkg::TIMER_DIV_DEF
) (
  input  logic [dit_pkg::SPAN_W-1:0]  span,
  output logic [dit_pkg::COUNT_W-1:0] load
);
  import dit_pkg::*;

  localparam longint unsigned DIV      = longint'(TIMER_DIV);
  localparam longint unsigned SPAN_MAX = 64'd1 << (SPAN_W - 1);
  // enough fraction bits that the rounding error stays under 1/TIMER_DIV
  localparam int FRAC = $clog2(SPAN_MAX * DIV) + 1;
  localparam longint unsigned RECIP = ((longint'(TICK_RATE) << FRAC) + DIV - 1) / DIV;
  localparam int RW  = $clog2(RECIP + 1);
  localparam int PW0 = SPAN_W + RW;
  localparam int PW  = (PW0 > FRAC + COUNT_W + 1) ? PW0 : FRAC + COUNT_W + 1;
  localparam int QW  = PW - FRAC;

  logic [PW-1:0] prod;
  logic [QW-1:0] quot;

  assign prod = PW'(span) * PW'(RECIP);
  assign quot = prod[PW-1:FRAC];

  always_comb begin
    if (|quot[QW-1:COUNT_W]) begin
      load = '1;
    end else if (quot[COUNT_W-1:0] == '0) begin
      load = COUNT_W'(1);
    end else begin
      load = quot[COUNT_W-1:0];
    end
  end

endmodule

### rtl/dit_timer.sv
// ----------------------------------------------------------------------------
// dit_timer
// One interval timer: run state, down counter with reload, and its flag.
// ----------------------------------------------------------------------------
module dit_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  dit_pkg::timer_ctl_t         ctl,
  input  logic [dit_pkg::COUNT_W-1:0] load,
  output logic                        flag,
  output logic                        flag_next
);
  import dit_pkg::*;

  logic               running;
  logic               running_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  always_comb begin
    running_next = running;
    count_next   = count;
    flag_next    = flag;
    if (ctl.mode_wr) begin
      if (ctl.clr) flag_next = 1'b0;
      if (ctl.run) begin
        // start only from idle, a running timer keeps its count
        if (!running) begin
          running_next = 1'b1;
          count_next   = load;
        end
      end else begin
        running_next = 1'b0;
        count_next   = '0;
      end
    end else if (ctl.tick && running && count != '0) begin
      if (count == COUNT_W'(1)) begin
        if (ctl.en) flag_next = 1'b1;
        count_next = load;
      end else begin
        count_next = count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      flag    <= 1'b0;
    end else begin
      running <= running_next;
      count   <= count_next;
      flag    <= flag_next;
    end
  end

`ifndef SYNTHESIS
  a_run_nonzero : assert property (@(posedge clk) disable iff (rst)
    running |-> count != '0) else $error("running timer holds zero count");
  a_idle_zero : assert property (@(posedge clk) disable iff (rst)
    !running |-> count == '0) else $error("idle timer holds a count");
  a_flag_on_tick : assert property (@(posedge clk) disable iff (rst)
    $rose(flag) |-> $past(ctl.tick) && $past(ctl.en))
    else $error("flag raised without an enabled tick");
`endif

endmodule

### rtl/dual_interval_timer_irq_core.sv
// ----------------------------------------------------------------------------
// dual_interval_timer_irq_core
// Timer pair behind a four-port byte bus, with status read and interrupt.
//
//   channel | dir | payload
//   s_*     | in  | tuser: opcode; tdata: port, data
//   m_*     | out | tdata: read_data, irq
//
// one transaction in, one transaction out, one per cycle sustained while m_tready holds
// two register stages: input register, then result register
// result registered once the m side is free, held in the result register until taken
// the load scaling is one multiplier per timer off the setting registers
// rst (synchronous) idles both timers, clears flags, mode register = 0x30
// a stalled m side holds one result and one item in the input register
// ----------------------------------------------------------------------------
module dual_interval_timer_irq_core #(
  parameter int TICK_RATE = dit_pkg::TICK_RATE_DEF,
  parameter int TIMER_DIV = dit_pkg::TIMER_DIV_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dit_pkg::S_TDATA_W-1:0] s_tdata,  // port[1:0], data[9:2], zero pad
  input  logic [dit_pkg::S_TUSER_W-1:0] s_tuser,  // opcode[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dit_pkg::M_TDATA_W-1:0] m_tdata   // read_data[7:0], irq[8], zero pad
);
  import dit_pkg::*;

  logic       in_valid;
  op_t        in_op;
  logic [1:0] in_port;
  logic [7:0] in_data;

  logic [7:0] address_latch;
  logic       bank_select;
  logic [9:0] timer_a_setting;
  logic [7:0] timer_b_setting;
  logic [7:0] mode_reg;

  logic [7:0] read_data;
  logic       irq;

  logic       advance;
  logic       reg_wr;
  logic       mode_wr;
  timer_ctl_t ctl_a;
  timer_ctl_t ctl_b;

  logic [SPAN_W-1:0]  span_a;
  logic [SPAN_W-1:0]  span_b;
  logic [8:0]         span_b_coarse;
  logic [COUNT_W-1:0] load_a;
  logic [COUNT_W-1:0] load_b;
  logic               flag_a;
  logic               flag_b;
  logic               flag_a_next;
  logic               flag_b_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tuser[1:0]);
      in_port <= s_tdata[1:0];
      in_data <= s_tdata[9:2];
    end
  end

  // register writes go through only with bank 0 on the data port
  assign reg_wr  = (in_op == OP_WRITE) && (in_port == PORT_DATA0) && !bank_select;
  assign mode_wr = advance && reg_wr && (address_latch == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      address_latch   <= '0;
      bank_select     <= 1'b0;
      timer_a_setting <= '0;
      timer_b_setting <= '0;
      mode_reg        <= MODE_RESET;
    end else if (advance && in_op == OP_WRITE) begin
      if (in_port inside {PORT_ADDR0, PORT_ADDR1}) begin
        address_latch <= in_data;
        bank_select   <= (in_port == PORT_ADDR1);
      end else if (reg_wr) begin
        case (address_latch)
          REG_TA_HI: timer_a_setting <= {in_data, timer_a_setting[1:0]};
          REG_TA_LO: timer_a_setting <= {timer_a_setting[9:2], in_data[1:0]};
          REG_TB:    timer_b_setting <= in_data;
          REG_MODE:  mode_reg        <= in_data;
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    ctl_a.tick    = advance && (in_op == OP_TICK);
    ctl_a.mode_wr = mode_wr;
    ctl_a.run     = in_data[MODE_RUN_A];
    ctl_a.en      = mode_reg[MODE_EN_A];
    ctl_a.clr     = in_data[MODE_CLR_A];
    ctl_b.tick    = advance && (in_op == OP_TICK);
    ctl_b.mode_wr = mode_wr;
    ctl_b.run     = in_data[MODE_RUN_B];
    ctl_b.en      = mode_reg[MODE_EN_B];
    ctl_b.clr     = in_data[MODE_CLR_B];
  end

  assign span_a        = SPAN_W'(TA_SPAN) - SPAN_W'(timer_a_setting);
  assign span_b_coarse = TB_SPAN - {1'b0, timer_b_setting};
  assign span_b        = SPAN_W'({span_b_coarse, 4'b0000});

  dit_scale #(
    .TICK_RATE (TICK_RATE),
    .TIMER_DIV (TIMER_DIV)
  ) u_scale_a (
    .span (span_a),
    .load (load_a)
  );

  dit_scale #(
    .TICK_RATE (TICK_RATE),
    .TIMER_DIV (TIMER_DIV)
  ) u_scale_b (
    .span (span_b),
    .load (load_b)
  );

  dit_timer u_timer_a (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_a),
    .load      (load_a),
    .flag      (flag_a),
    .flag_next (flag_a_next)
  );

  dit_timer u_timer_b (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_b),
    .load      (load_b),
    .flag      (flag_b),
    .flag_next (flag_b_next)
  );

  always_comb begin
    read_data = '0;
    if (in_op == OP_READ && in_port == PORT_ADDR0) begin
      read_data = {6'b000000, flag_b_next, flag_a_next};
    end
    irq = flag_a_next | flag_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= M_TDATA_W'({irq, read_data});
    end
  end

`ifndef SYNTHESIS
  a_status_bits : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'd0 && m_tdata[M_TDATA_W-1:9] == '0)
    else $error("unused result bits set");
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready) else $error("empty input stage not ready");
  a_clear_both : assert property (@(posedge clk) disable iff (rst)
    mode_wr && ctl_a.clr && ctl_b.clr |=> !flag_a && !flag_b)
    else $error("flags survive a clear of both");
  a_irq_flags : assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tdata[8] == (flag_a || flag_b))
    else $error("irq disagrees with flags");
`endif

endmodule
